// File: design/trmax_pkg.sv
package trmax_pkg;

    // Fixed field widths
    localparam int SIZE_W      = 11;
    localparam int CFG_DIMS    = 4;
    localparam int IDX_W       = 10;
    localparam int ELEM_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - ELEM_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_MASK = 3'd5;

    // Element type codes; the unused code behaves as int32
    localparam logic [1:0] ET_FLOAT = 2'd0;
    localparam logic [1:0] ET_INT32 = 2'd1;
    localparam logic [1:0] ET_INT8  = 2'd2;

    typedef struct packed {
        logic first;
        logic last;
        logic done;
    } t_grp_flags;

    typedef struct packed {
        logic              done;
        logic [ELEM_W-1:0] max_bits;
        logic [IDX_W-1:0]  out_index;
    } t_result;

    function automatic logic f_is_nan(input logic [ELEM_W-1:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != '0);
    endfunction

    function automatic logic [ELEM_W-1:0] f_key(input logic [ELEM_W-1:0] b);
        return b[31] ? ~b : (b | 32'h8000_0000);
    endfunction

    // True when the stored value is strictly below the newcomer
    function automatic logic f_stored_less(input logic [ELEM_W-1:0] stored,
                                           input logic [ELEM_W-1:0] fresh,
                                           input logic              is_float);
        logic res;
        if (is_float) begin
            if (f_is_nan(stored) || f_is_nan(fresh)) begin
                res = 1'b0;
            end else if ((stored[30:0] == '0) && (fresh[30:0] == '0)) begin
                res = 1'b0;
            end else begin
                res = f_key(stored) < f_key(fresh);
            end
        end else begin
            res = (stored ^ 32'h8000_0000) < (fresh ^ 32'h8000_0000);
        end
        return res;
    endfunction

endpackage

// File: design/tensor_reduce_max_axes.sv
// Streaming max-reduction over selected axes of a tensor of up to RANK dims.
// Slave stream: one 32-bit element word per handshake, row-major order,
// innermost dimension fastest. Master stream: one word per finished group,
// tdata = {pad, max_bits, out_index}, tlast marks the last group of a tensor.
// Config channel: index selects element type, the four sizes or the reduce
// mask; it is always ready and must only be used while the block is idle.
// Throughput: one element per cycle while the slave side is ready. Each element is one
// read-modify-write of the running-max memory; a repeat of the same entry in
// the next cycle is served from a forwarding register.
// A group's result is registered in the store stage and then in the output
// queue before it is offered on the master side.
// A write to a size or the mask reloads the output-index registers from the
// position counters, bit by bit for each dimension, during which the slave
// side is held not ready.
// Reset: counters and indexes clear, config takes its defaults (float, all
// sizes 1, nothing reduced); the memory holds garbage until written.
// Receiver stall: a three-word output queue absorbs results; the slave side
// drops ready once the queue plus the word in flight would fill it.
module tensor_reduce_max_axes #(
    parameter int RANK      = 4,
    parameter int OUT_DEPTH = 1024,
    parameter int DIM_MAX   = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // element_bits[31:0]
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [trmax_pkg::ELEM_W-1:0]       i_s_axis_tdata,
    // out_index[9:0], max_bits[41:10], zero pad[47:42]
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [trmax_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [trmax_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [trmax_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import trmax_pkg::*;

    localparam int MW = $clog2(OUT_DEPTH);

    // Configuration registers
    logic [1:0]          r_elem_type;
    logic [SIZE_W-1:0]   r_dim_size [CFG_DIMS];
    logic [CFG_DIMS-1:0] r_reduce_mask;

    logic                w_cfg_wr;
    logic                w_recalc;
    logic                w_accept;
    logic                w_busy;
    logic [MW-1:0]       w_idx;
    t_grp_flags          w_flags;
    logic [ELEM_W-1:0]   w_elem;
    logic                w_pend;
    logic                w_push;
    t_result             w_res;
    t_result             w_out;
    logic [1:0]          w_count;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_type   <= ET_FLOAT;
            r_reduce_mask <= '0;
            for (int k = 0; k < CFG_DIMS; k++) begin
                r_dim_size[k] <= SIZE_W'(1);
            end
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_ELEM_TYPE:   r_elem_type   <= i_cfg_data[1:0];
                CFG_DIM_SIZE_0:  r_dim_size[0] <= i_cfg_data;
                CFG_DIM_SIZE_1:  r_dim_size[1] <= i_cfg_data;
                CFG_DIM_SIZE_2:  r_dim_size[2] <= i_cfg_data;
                CFG_DIM_SIZE_3:  r_dim_size[3] <= i_cfg_data;
                CFG_REDUCE_MASK: r_reduce_mask <= i_cfg_data[CFG_DIMS-1:0];
                default: ;
            endcase
        end
    end

    // Reload indexes whenever a size or the reduce mask is written
    assign w_recalc = w_cfg_wr &&
                      ((i_cfg_index == CFG_DIM_SIZE_0) || (i_cfg_index == CFG_DIM_SIZE_1) ||
                       (i_cfg_index == CFG_DIM_SIZE_2) || (i_cfg_index == CFG_DIM_SIZE_3) ||
                       (i_cfg_index == CFG_REDUCE_MASK));

    // Hold input while reloading or while the output queue could overflow
    assign o_s_axis_tready = !w_busy && ((3'(w_count) + 3'(w_pend)) <= 3'd2);
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;

    // int8 takes the low byte, sign-extended
    assign w_elem = (r_elem_type == ET_INT8) ?
                    {{(ELEM_W-8){i_s_axis_tdata[7]}}, i_s_axis_tdata[7:0]} : i_s_axis_tdata;

    trmax_index #(
        .RANK      (RANK),
        .OUT_DEPTH (OUT_DEPTH),
        .DIM_MAX   (DIM_MAX)
    ) u_index (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dim_size    (r_dim_size),
        .i_reduce_mask (r_reduce_mask),
        .i_recalc      (w_recalc),
        .i_step        (w_accept),
        .o_busy        (w_busy),
        .o_idx         (w_idx),
        .o_flags       (w_flags)
    );

    trmax_store #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_idx      (w_idx),
        .i_data     (w_elem),
        .i_flags    (w_flags),
        .i_is_float (r_elem_type == ET_FLOAT),
        .o_pend     (w_pend),
        .o_push     (w_push),
        .o_result   (w_res)
    );

    trmax_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out),
        .o_count (w_count)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_out.max_bits, w_out.out_index};
    assign o_m_axis_tlast = w_out.done;

endmodule

// File: design/trmax_index.sv
module trmax_index #(
    parameter int RANK      = 4,
    parameter int OUT_DEPTH = 1024,
    parameter int DIM_MAX   = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [trmax_pkg::SIZE_W-1:0]  i_dim_size [trmax_pkg::CFG_DIMS],
    input  logic [trmax_pkg::CFG_DIMS-1:0] i_reduce_mask,
    input  logic                          i_recalc,
    input  logic                          i_step,
    output logic                          o_busy,
    output logic [$clog2(OUT_DEPTH)-1:0]  o_idx,
    output trmax_pkg::t_grp_flags         o_flags
);
    import trmax_pkg::*;

    localparam int SZ_MAX = (DIM_MAX < 2047) ? DIM_MAX : 2047;
    localparam int CW     = $clog2(SZ_MAX);
    localparam int EW     = $clog2(SZ_MAX + 1);
    localparam int MW     = $clog2(OUT_DEPTH);
    localparam int BW     = $clog2(EW);
    localparam logic [MW:0] MOD = (MW+1)'(OUT_DEPTH);

    function automatic logic [MW-1:0] f_modadd(input logic [MW-1:0] a,
                                               input logic [MW-1:0] b);
        logic [MW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD) s = s - MOD;
        return s[MW-1:0];
    endfunction

    // 2*a + bit, reduced
    function automatic logic [MW-1:0] f_dbl(input logic [MW-1:0] a, input logic bit_in);
        logic [MW:0] s;
        s = {a, bit_in};
        if (s >= MOD) s = s - MOD;
        return s[MW-1:0];
    endfunction

    logic [CW-1:0]   r_cnt   [RANK];
    logic [MW-1:0]   r_snap  [RANK];   // index with all inner digits zeroed
    logic [MW-1:0]   r_q     [RANK];   // weight of each digit
    logic [MW-1:0]   r_sr    [RANK];
    logic [MW-1:0]   r_qr    [RANK];
    logic [MW-1:0]   r_x;
    logic            r_busy;
    logic            r_add;
    logic [BW-1:0]   r_bit;
    logic [RANK-1:0] r_dim_oh;

    logic [EW-1:0]   w_eff   [RANK];
    logic [EW-1:0]   w_nxt   [RANK];
    logic [RANK-1:0] w_red, w_wrap, w_end, w_zero, w_carry, w_use;
    logic [MW-1:0]   w_new_v;
    logic [EW-1:0]   w_sel_eff, w_sel_cnt;
    logic            w_sel_red;
    logic            w_eff_bit, w_cnt_bit;
    logic [MW-1:0]   w_sr_nxt [RANK];
    logic [MW-1:0]   w_qr_nxt [RANK];

    for (genvar k = 0; k < RANK; k++) begin : g_dim
        if (k < CFG_DIMS) begin : g_cfg
            always_comb begin
                if (i_dim_size[k] == '0) begin
                    w_eff[k] = EW'(1);
                end else if (32'(i_dim_size[k]) > DIM_MAX) begin
                    w_eff[k] = EW'(DIM_MAX);
                end else begin
                    w_eff[k] = EW'(i_dim_size[k]);
                end
            end
            assign w_red[k] = i_reduce_mask[k];
        end else begin : g_fix
            assign w_eff[k] = EW'(1);
            assign w_red[k] = 1'b0;
        end
        assign w_nxt[k]  = EW'(r_cnt[k]) + EW'(1);
        assign w_wrap[k] = (w_nxt[k] >= w_eff[k]);
        assign w_end[k]  = (EW'(r_cnt[k]) == (w_eff[k] - EW'(1)));
        assign w_zero[k] = (r_cnt[k] == '0);
    end

    // carry into digit k: every inner digit wraps
    always_comb begin
        w_carry[RANK-1] = 1'b1;
        for (int k = RANK - 2; k >= 0; k--) begin
            w_carry[k] = w_carry[k+1] & w_wrap[k+1];
        end
    end

    // index after the step: digit that advances adds its weight
    always_comb begin
        w_new_v = '0;
        for (int k = 0; k < RANK; k++) begin
            if (w_carry[k] && !w_wrap[k]) begin
                w_new_v = f_modadd(r_snap[k], w_red[k] ? '0 : r_q[k]);
            end
        end
    end

    assign o_flags.first = &(~w_red | w_zero);
    assign o_flags.last  = &(~w_red | w_end);
    assign o_flags.done  = &w_end;
    assign o_idx         = r_snap[RANK-1];
    assign o_busy        = r_busy;

    // recompute datapath: one bit of the current size per cycle
    always_comb begin
        w_sel_eff = '0;
        w_sel_cnt = '0;
        w_sel_red = 1'b0;
        for (int k = 0; k < RANK; k++) begin
            if (r_dim_oh[k]) begin
                w_sel_eff = w_sel_eff | w_eff[k];
                w_sel_cnt = w_sel_cnt | EW'(r_cnt[k]);
                w_sel_red = w_sel_red | w_red[k];
            end
        end
    end

    assign w_eff_bit = w_sel_eff[r_bit];
    assign w_cnt_bit = w_sel_cnt[r_bit];

    always_comb begin
        w_use[0] = r_dim_oh[0];
        for (int k = 1; k < RANK; k++) begin
            w_use[k] = w_use[k-1] | r_dim_oh[k];
        end
    end

    always_comb begin
        for (int k = 0; k < RANK; k++) begin
            w_sr_nxt[k] = f_dbl(r_sr[k], 1'b0);
            w_qr_nxt[k] = f_dbl(r_qr[k], 1'b0);
            if (w_eff_bit) begin
                w_sr_nxt[k] = f_modadd(w_sr_nxt[k], r_snap[k]);
                w_qr_nxt[k] = f_modadd(w_qr_nxt[k], r_q[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_add    <= 1'b0;
            r_bit    <= BW'(EW - 1);
            r_dim_oh <= RANK'(1);
            r_x      <= '0;
            for (int k = 0; k < RANK; k++) begin
                r_cnt[k]  <= '0;
                r_snap[k] <= '0;
                r_q[k]    <= MW'(1);
                r_sr[k]   <= '0;
                r_qr[k]   <= '0;
            end
        end else if (i_recalc) begin
            r_busy   <= 1'b1;
            r_add    <= 1'b0;
            r_bit    <= BW'(EW - 1);
            r_dim_oh <= RANK'(1);
            r_x      <= '0;
            for (int k = 0; k < RANK; k++) begin
                r_snap[k] <= '0;
                r_q[k]    <= '0;
                r_sr[k]   <= '0;
                r_qr[k]   <= '0;
            end
        end else if (r_busy) begin
            if (!r_add) begin
                for (int k = 0; k < RANK; k++) begin
                    r_sr[k] <= w_sr_nxt[k];
                    r_qr[k] <= w_qr_nxt[k];
                end
                r_x <= f_dbl(r_x, w_cnt_bit);
                if (r_bit == '0) begin
                    r_add <= 1'b1;
                end else begin
                    r_bit <= r_bit - BW'(1);
                end
            end else begin
                for (int k = 0; k < RANK; k++) begin
                    if (!w_sel_red) begin
                        r_snap[k] <= f_modadd(r_sr[k], w_use[k] ? r_x : '0);
                        r_q[k]    <= f_modadd(r_qr[k], r_dim_oh[k] ? MW'(1) : '0);
                    end
                    r_sr[k] <= '0;
                    r_qr[k] <= '0;
                end
                r_x   <= '0;
                r_add <= 1'b0;
                r_bit <= BW'(EW - 1);
                if (r_dim_oh[RANK-1]) begin
                    r_busy <= 1'b0;
                end else begin
                    r_dim_oh <= r_dim_oh << 1;
                end
            end
        end else if (i_step) begin
            for (int k = 0; k < RANK; k++) begin
                if (w_carry[k]) begin
                    r_cnt[k]  <= w_wrap[k] ? '0 : CW'(w_nxt[k]);
                    r_snap[k] <= w_new_v;
                end
            end
        end
    end

endmodule

// File: design/trmax_store.sv
module trmax_store #(
    parameter int OUT_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [$clog2(OUT_DEPTH)-1:0]  i_idx,
    input  logic [trmax_pkg::ELEM_W-1:0]  i_data,
    input  trmax_pkg::t_grp_flags         i_flags,
    input  logic                          i_is_float,
    output logic                          o_pend,
    output logic                          o_push,
    output trmax_pkg::t_result            o_result
);
    import trmax_pkg::*;

    localparam int MW = $clog2(OUT_DEPTH);

    logic [ELEM_W-1:0] r_mem [OUT_DEPTH];
    logic [ELEM_W-1:0] r_rdata;

    logic              r_s1_vld;
    logic [MW-1:0]     r_s1_idx;
    logic [ELEM_W-1:0] r_s1_data;
    t_grp_flags        r_s1_flags;
    logic              r_s1_float;

    logic              r_fw_vld;
    logic [MW-1:0]     r_fw_idx;
    logic [ELEM_W-1:0] r_fw_val;

    logic [ELEM_W-1:0] w_stored;
    logic [ELEM_W-1:0] w_new;
    logic              w_wr;

    // the word written last cycle is not yet in the read data
    assign w_stored = (r_fw_vld && (r_fw_idx == r_s1_idx)) ? r_fw_val : r_rdata;
    assign w_wr     = r_s1_vld &&
                      (r_s1_flags.first || f_stored_less(w_stored, r_s1_data, r_s1_float));
    assign w_new    = w_wr ? r_s1_data : w_stored;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_s1_idx] <= r_s1_data;
        end
        if (i_valid) begin
            r_rdata <= r_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
            r_fw_vld <= r_s1_vld;
        end
        if (i_valid) begin
            r_s1_idx   <= i_idx;
            r_s1_data  <= i_data;
            r_s1_flags <= i_flags;
            r_s1_float <= i_is_float;
        end
        r_fw_idx <= r_s1_idx;
        r_fw_val <= w_new;
    end

    assign o_pend             = r_s1_vld & r_s1_flags.last;
    assign o_push             = r_s1_vld & r_s1_flags.last;
    assign o_result.out_index = IDX_W'(r_s1_idx);
    assign o_result.max_bits  = w_new;
    assign o_result.done      = r_s1_flags.done;

endmodule

// File: design/trmax_out_fifo.sv
module trmax_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  trmax_pkg::t_result i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output trmax_pkg::t_result o_data,
    output logic [1:0]         o_count
);
    import trmax_pkg::*;

    localparam logic [1:0] LAST_SLOT = 2'd2;

    t_result    r_data [3];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_data[r_rp];
    assign o_count = r_cnt;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_SLOT) ? '0 : r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == LAST_SLOT) ? '0 : r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

endmodule
